// ----- design/mpk_pkg.sv -----
package mpk_pkg;

  // position inside a frame, wide enough for the largest supported frame
  localparam int unsigned POS_W = 6;

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] PAD_BYTE    = 8'hFD;
  localparam logic [7:0] TERM_BYTE   = 8'h00;

  typedef enum logic [1:0] {
    MODE_SEEK    = 2'd0,
    MODE_COLLECT = 2'd1,
    MODE_SYSEX   = 2'd2
  } mode_e;

  // output work caused by one input byte
  typedef struct packed {
    logic [2:0][7:0]  msg;   // message bytes, msg[0] goes out first
    logic [1:0]       cnt;   // message bytes still to send
    logic             fin;   // pad and terminate once message bytes are out
    logic [POS_W-1:0] used;  // frame bytes already sent
  } job_t;

  // total length of a channel message, 0 for anything else
  function automatic logic [1:0] msg_len(input logic [7:0] s);
    logic [1:0] len;
    case (s[7:4])
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd3;
      4'hC, 4'hD:                   len = 2'd2;
      default:                      len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- design/mpk_parser.sv -----
module mpk_parser import mpk_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 42
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] data_byte_i,
  input  logic       packet_end_i,
  output job_t       job_o,
  output logic       job_load_o
);

  localparam logic [POS_W-1:0] LastPos = POS_W'(FRAME_BYTES - 1);

  mode_e            mode_q, mode_d;
  logic [7:0]       status_q, status_d;
  logic [7:0]       data_q, data_d;
  logic [1:0]       need_q, need_d;
  logic [POS_W-1:0] count_q, count_d;
  logic             room;

  assign room = (count_q < LastPos);

  always_comb begin
    mode_d   = mode_q;
    status_d = status_q;
    data_d   = data_q;
    need_d   = need_q;
    count_d  = count_q;
    job_o    = '0;
    job_o.msg[0] = data_byte_i;
    unique case (mode_q)
      MODE_SYSEX: begin
        job_o.cnt  = {1'b0, room};
        job_o.fin  = packet_end_i;
        job_o.used = count_q;
        if (packet_end_i) begin
          count_d = '0;
          mode_d  = MODE_SEEK;
        end else if (room) begin
          count_d = count_q + POS_W'(1);
        end
      end
      MODE_COLLECT: begin
        if (need_q == 2'd2) begin
          if (packet_end_i) begin
            mode_d = MODE_SEEK;
            need_d = '0;
            // cut-off message, the last byte may still open a one-byte sysex
            if (data_byte_i == SYSEX_START) begin
              job_o.cnt = 2'd1;
              job_o.fin = 1'b1;
              count_d   = '0;
            end
          end else begin
            data_d = data_byte_i;
            need_d = 2'd1;
          end
        end else begin
          job_o.msg[0] = status_q;
          job_o.fin    = 1'b1;
          if (msg_len(status_q) == 2'd3) begin
            job_o.msg[1] = data_q;
            job_o.msg[2] = data_byte_i;
            job_o.cnt    = 2'd3;
          end else begin
            job_o.msg[1] = data_byte_i;
            job_o.cnt    = 2'd2;
          end
          mode_d = MODE_SEEK;
          need_d = '0;
        end
      end
      default: begin
        mode_d = MODE_SEEK;
        if (data_byte_i == SYSEX_START) begin
          job_o.cnt = 2'd1;
          job_o.fin = packet_end_i;
          count_d   = packet_end_i ? '0 : POS_W'(1);
          mode_d    = packet_end_i ? MODE_SEEK : MODE_SYSEX;
        end else if (msg_len(data_byte_i) != 2'd0 && !packet_end_i) begin
          status_d = data_byte_i;
          need_d   = msg_len(data_byte_i) - 2'd1;
          mode_d   = MODE_COLLECT;
        end
      end
    endcase
  end

  assign job_load_o = fire_i && (job_o.cnt != 2'd0 || job_o.fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SEEK;
      status_q <= '0;
      data_q   <= '0;
      need_q   <= '0;
      count_q  <= '0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      status_q <= status_d;
      data_q   <= data_d;
      need_q   <= need_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- design/mpk_emitter.sv -----
module mpk_emitter import mpk_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 42
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       job_load_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_last_o
);

  localparam logic [POS_W-1:0] LastPos = POS_W'(FRAME_BYTES - 1);

  job_t       job_q, job_d;
  logic       job_v_q;
  logic       out_v_q;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       advance;
  logic       done;

  assign advance = job_v_q && (!out_v_q || out_ready_i);

  always_comb begin
    job_d  = job_q;
    byte_d = TERM_BYTE;
    last_d = 1'b0;
    done   = 1'b0;
    if (job_q.cnt != 2'd0) begin
      byte_d       = job_q.msg[0];
      job_d.msg[0] = job_q.msg[1];
      job_d.msg[1] = job_q.msg[2];
      job_d.cnt    = job_q.cnt - 2'd1;
      job_d.used   = job_q.used + POS_W'(1);
      done         = (job_q.cnt == 2'd1) && !job_q.fin;
    end else if (job_q.used < LastPos) begin
      byte_d     = PAD_BYTE;
      job_d.used = job_q.used + POS_W'(1);
    end else begin
      last_d = 1'b1;
      done   = 1'b1;
    end
  end

  // a new transaction may enter as the current job sends its final byte
  assign free_o = !job_v_q || (advance && done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (job_load_i) begin
        job_v_q <= 1'b1;
      end else if (advance && done) begin
        job_v_q <= 1'b0;
      end
      if (advance) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load_i) begin
      job_q <= job_i;
    end else if (advance) begin
      job_q <= job_d;
    end
    if (advance) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign frame_byte_o = byte_q;
  assign frame_last_o = last_q;

endmodule

// ----- design/midi_message_frame_packer.sv -----
// MIDI message frame packer
// input channel: in_valid_i / in_ready_o carry one MIDI byte (data_byte_i)
// and packet_end_i, high on the last byte of a host packet
// output channel: out_valid_o / out_ready_i carry frame_byte_o and
// frame_last_o, high on the 0x00 terminator closing each FRAME_BYTES frame
// every complete channel message becomes one frame: message bytes, 0xFD
// padding, terminator; sysex frames stream each byte as it arrives and are
// padded and terminated at packet end
// output path: each job is registered in the emitter, which sends one
// byte per cycle via its output byte register while the receiver is ready
// throughput: one input byte per cycle while the receiver is ready and each
// byte causes at most one output byte (sysex body, stray bytes, partial
// messages); a byte that completes a frame holds the input while the frame
// emitter sends the rest of the frame one byte per cycle
// reset clears parser state and drops any frame being emitted
// when the receiver stalls, the output byte holds and the emitter stops;
// input is refused once the pending job cannot drain
module midi_message_frame_packer import mpk_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 42
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       packet_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_last_o
);

  job_t job;
  logic job_load;
  logic fire;

  assign fire = in_valid_i && in_ready_o;

  mpk_parser #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .data_byte_i (data_byte_i),
    .packet_end_i(packet_end_i),
    .job_o       (job),
    .job_load_o  (job_load)
  );

  mpk_emitter #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_load_i  (job_load),
    .free_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .frame_byte_o(frame_byte_o),
    .frame_last_o(frame_last_o)
  );

endmodule

// ----- design/mpk_checker.sv -----
module mpk_checker import mpk_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 42
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] frame_byte_o,
  input logic       frame_last_o
);

  localparam logic [POS_W-1:0] LastPos = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0] pos_q;
  logic             out_fire;

  assign out_fire = out_valid_o && out_ready_i;

  // byte position inside the current frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (out_fire) begin
      pos_q <= frame_last_o ? '0 : pos_q + POS_W'(1);
    end
  end

  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> pos_q == LastPos)
    else $error("frame ended at the wrong byte position");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pos_q == LastPos |-> frame_last_o)
    else $error("frame too long");

  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> frame_byte_o == TERM_BYTE)
    else $error("terminator byte not zero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(frame_byte_o) && $stable(frame_last_o))
    else $error("stalled output transaction changed");

endmodule

bind midi_message_frame_packer mpk_checker #(
  .FRAME_BYTES(FRAME_BYTES)
) u_mpk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .frame_byte_o(frame_byte_o),
  .frame_last_o(frame_last_o)
);
